/* rtl/core/pos_pkg.sv */
// Package for the popcorn orbit step: widths, CORDIC constants, register codes.
// Used by every module under rtl/core.
package pos_pkg;

    localparam int FRAC_BITS_DEF     = 24;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int ANG_W             = 36;
    localparam int SC_W              = 34;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [SC_W-1:0]  GAIN_Q30    = 34'sd652032874;

    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_CRE   = 2'd1;
    localparam logic [1:0] REG_CIM   = 2'd2;
    localparam logic [1:0] REG_BAIL  = 2'd3;

    // arctangent of 2^-i in Q30
    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] t;
        begin
            case (i)
                0: t = 36'sd843314857;
                1: t = 36'sd497837829;
                2: t = 36'sd263043837;
                3: t = 36'sd133525159;
                4: t = 36'sd67021687;
                5: t = 36'sd33543516;
                6: t = 36'sd16775851;
                7: t = 36'sd8388437;
                8: t = 36'sd4194283;
                9: t = 36'sd2097149;
                default: t = (i < 31) ? (36'sd1 <<< (30 - i)) : 36'sd0;
            endcase
            return t;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

endpackage

/* rtl/core/pos_cordic_cell.sv */
// One CORDIC rotation cell: one micro-rotation, registered, with sideband.
// Depends on pos_pkg.
module pos_cordic_cell #(
    parameter int SHIFT = 0,
    parameter int SB_W  = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld_in,
    input  logic signed [pos_pkg::SC_W-1:0]  x_in,
    input  logic signed [pos_pkg::SC_W-1:0]  y_in,
    input  logic signed [pos_pkg::ANG_W-1:0] r_in,
    input  logic [SB_W-1:0]                sb_in,
    output logic                           vld_out,
    output logic signed [pos_pkg::SC_W-1:0]  x_out,
    output logic signed [pos_pkg::SC_W-1:0]  y_out,
    output logic signed [pos_pkg::ANG_W-1:0] r_out,
    output logic [SB_W-1:0]                sb_out
);
    localparam logic signed [pos_pkg::ANG_W-1:0] ATAN = pos_pkg::atan_q30(SHIFT);

    logic signed [pos_pkg::SC_W-1:0] dx, dy;
    logic signed [pos_pkg::SC_W-1:0] x_next, y_next;
    logic signed [pos_pkg::ANG_W-1:0] r_next;

    // rotate toward zero residual angle
    always_comb
    begin
        dx = x_in >>> SHIFT;
        dy = y_in >>> SHIFT;
        if (!r_in[pos_pkg::ANG_W-1])
        begin
            x_next = x_in - dy;
            y_next = y_in + dx;
            r_next = r_in - ATAN;
        end
        else
        begin
            x_next = x_in + dy;
            y_next = y_in - dx;
            r_next = r_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out <= 1'b0;
        else
            vld_out <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        x_out  <= x_next;
        y_out  <= y_next;
        r_out  <= r_next;
        sb_out <= sb_in;
    end
endmodule

/* rtl/core/pos_sincos.sv */
// Pipelined sin/cos: range reduction cells, fold stage, then a chain of CORDIC cells.
// Depends on pos_pkg and pos_cordic_cell.
module pos_sincos #(
    parameter int FRAC_BITS     = pos_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = pos_pkg::CORDIC_STAGES_DEF,
    parameter int SB_W          = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vld_in,
    input  logic signed [31:0]            ang_in,
    input  logic [SB_W-1:0]               sb_in,
    output logic                          vld_out,
    output logic signed [pos_pkg::SC_W-1:0] sin_out,
    output logic signed [pos_pkg::SC_W-1:0] cos_out,
    output logic [SB_W-1:0]               sb_out
);
    localparam int AW = pos_pkg::ANG_W;
    localparam int SW = pos_pkg::SC_W;
    localparam int NST = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    // |angle| in Q30 stays below 2pi * 2^NRD, so NRD subtract cells reduce it
    localparam int NRD = (FRAC_BITS < 29) ? 29 - FRAC_BITS : 1;
    localparam int LW  = (FRAC_BITS < 29) ? 62 - FRAC_BITS : 34;

    logic signed [LW:0]   a_ext;
    logic [LW-1:0]        mag_in;
    logic [LW-1:0]        m_c   [0:NRD];
    logic                 n_c   [0:NRD];
    logic                 vr_c  [0:NRD];
    logic [SB_W-1:0]      sbr_c [0:NRD];
    logic signed [AW-1:0] ar, red;
    logic                 flip;
    logic                 v_reg [0:NST];
    logic signed [SW-1:0] x_c [0:NST];
    logic signed [SW-1:0] y_c [0:NST];
    logic signed [AW-1:0] r_c [0:NST];
    logic [SB_W:0]        s_c [0:NST];
    logic                 v0_reg;
    logic signed [AW-1:0] r0_reg;
    logic [SB_W:0]        s0_reg;

    // Q30 angle as sign and magnitude
    always_comb
    begin
        a_ext  = (LW+1)'(ang_in) <<< (30 - FRAC_BITS);
        mag_in = a_ext[LW] ? LW'(-a_ext) : LW'(a_ext);
    end

    assign vr_c[0]  = vld_in;
    assign m_c[0]   = mag_in;
    assign n_c[0]   = a_ext[LW];
    assign sbr_c[0] = sb_in;

    // magnitude modulo 2pi, one conditional subtract of 2pi * 2^k per cell
    for (genvar g = 0; g < NRD; g++)
    begin : g_red
        localparam logic [LW-1:0] SUB = LW'(pos_pkg::TWO_PI_Q30) << (NRD - 1 - g);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vr_c[g+1] <= 1'b0;
            else
                vr_c[g+1] <= vr_c[g];
        end
        always_ff @(posedge clk)
        begin
            m_c[g+1]   <= (m_c[g] >= SUB) ? m_c[g] - SUB : m_c[g];
            n_c[g+1]   <= n_c[g];
            sbr_c[g+1] <= sbr_c[g];
        end
    end

    // restore sign into [0, 2pi), move to (-pi, pi], fold into [-pi/2, pi/2]
    always_comb
    begin
        ar = $signed(AW'(m_c[NRD]));
        if (n_c[NRD] && m_c[NRD] != '0)
            ar = pos_pkg::TWO_PI_Q30 - ar;
        if (ar > pos_pkg::PI_Q30)
            ar = ar - pos_pkg::TWO_PI_Q30;
        flip = 1'b0;
        red = ar;
        if (ar > pos_pkg::HALF_PI_Q30)
        begin
            red = pos_pkg::PI_Q30 - ar;
            flip = 1'b1;
        end
        else if (ar < -pos_pkg::HALF_PI_Q30)
        begin
            red = -pos_pkg::PI_Q30 - ar;
            flip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= vr_c[NRD];
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= red;
        s0_reg <= {flip, sbr_c[NRD]};
    end

    assign v_reg[0] = v0_reg;
    assign x_c[0]   = pos_pkg::GAIN_Q30;
    assign y_c[0]   = '0;
    assign r_c[0]   = r0_reg;
    assign s_c[0]   = s0_reg;

    // chain of rotation cells
    for (genvar g = 0; g < NST; g++)
    begin : g_cell
        pos_cordic_cell #(.SHIFT(g), .SB_W(SB_W + 1)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .vld_in(v_reg[g]), .x_in(x_c[g]), .y_in(y_c[g]), .r_in(r_c[g]),
            .sb_in(s_c[g]),
            .vld_out(v_reg[g+1]), .x_out(x_c[g+1]), .y_out(y_c[g+1]),
            .r_out(r_c[g+1]), .sb_out(s_c[g+1])
        );
    end

    assign vld_out = v_reg[NST];
    assign sin_out = y_c[NST];
    assign cos_out = s_c[NST][SB_W] ? -x_c[NST] : x_c[NST];
    assign sb_out  = s_c[NST][SB_W-1:0];
endmodule

/* rtl/core/pos_divider.sv */
// Pipelined signed divider: one quotient bit per cell, truncating toward zero,
// saturated to 32 bits, with cos == 0 pole handling. Depends on pos_pkg.
module pos_divider #(
    parameter int FRAC_BITS = pos_pkg::FRAC_BITS_DEF,
    parameter int SB_W      = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vld_in,
    input  logic signed [pos_pkg::SC_W-1:0] num_in,
    input  logic signed [pos_pkg::SC_W-1:0] den_in,
    input  logic [SB_W-1:0]               sb_in,
    output logic                          vld_out,
    output logic signed [31:0]            quo_out,
    output logic [SB_W-1:0]               sb_out
);
    // |sin| <= 2^30 roughly, shifted by FRAC_BITS; quotient beyond 34 bits saturates
    localparam int NW = pos_pkg::SC_W + FRAC_BITS;
    localparam int QB = 34;
    localparam int DW = pos_pkg::SC_W;

    logic               v_p [0:QB];
    logic [NW-1:0]      n_p [0:QB];
    logic [DW+QB-1:0]   rm_p [0:QB];
    logic [DW-1:0]      d_p [0:QB];
    logic [QB-1:0]      q_p [0:QB];
    logic               ng_p [0:QB];
    logic               big_p [0:QB];
    logic               pole_p [0:QB];
    logic               pos_p [0:QB];
    logic [SB_W-1:0]    sb_p [0:QB];

    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic signed [NW-1:0] num_ext;

    always_comb
    begin
        num_ext = NW'(num_in) <<< FRAC_BITS;
        num_mag = num_ext[NW-1] ? NW'(-num_ext) : num_ext;
        den_mag = den_in[DW-1] ? DW'(-den_in) : DW'(den_in);
    end

    assign v_p[0]    = vld_in;
    assign n_p[0]    = num_mag;
    // upper numerator bits start as the partial remainder
    assign rm_p[0]   = (DW+QB)'(num_mag >> QB);
    assign d_p[0]    = den_mag;
    assign q_p[0]    = '0;
    assign ng_p[0]   = num_in[DW-1] ^ den_in[DW-1];
    // quotient magnitude needs bits beyond QB: saturate
    assign big_p[0]  = (num_mag >> QB) >= NW'(den_mag);
    assign pole_p[0] = (den_in == '0);
    assign pos_p[0]  = !num_in[DW-1];
    assign sb_p[0]   = sb_in;

    // restoring division, one bit per registered cell
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        logic [DW+QB-1:0] trial;
        logic [DW+QB-1:0] rem_sh;
        logic             qbit;
        always_comb
        begin
            rem_sh = {rm_p[g][DW+QB-2:0], n_p[g][QB-1-g]};
            trial  = rem_sh - (DW+QB)'(d_p[g]);
            qbit   = (rem_sh >= (DW+QB)'(d_p[g]));
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_p[g+1] <= 1'b0;
            else
                v_p[g+1] <= v_p[g];
        end
        always_ff @(posedge clk)
        begin
            n_p[g+1]    <= n_p[g];
            rm_p[g+1]   <= qbit ? trial : rem_sh;
            q_p[g+1]    <= {q_p[g][QB-2:0], qbit};
            d_p[g+1]    <= d_p[g];
            ng_p[g+1]   <= ng_p[g];
            big_p[g+1]  <= big_p[g];
            pole_p[g+1] <= pole_p[g];
            pos_p[g+1]  <= pos_p[g];
            sb_p[g+1]   <= sb_p[g];
        end
    end

    logic signed [63:0] qs;
    always_comb
    begin
        qs = ng_p[QB] ? -$signed({30'd0, q_p[QB]}) : $signed({30'd0, q_p[QB]});
        if (pole_p[QB])
            quo_out = pos_p[QB] ? 32'sh7fffffff : 32'sh80000000;
        else if (big_p[QB])
            quo_out = ng_p[QB] ? 32'sh80000000 : 32'sh7fffffff;
        else
            quo_out = pos_pkg::sat32(qs);
    end

    assign vld_out = v_p[QB];
    assign sb_out  = sb_p[QB];
endmodule

/* rtl/core/popcorn_orbit_step.sv */
// Popcorn orbit step: top level with APB registers and the full pipeline.
// Depends on pos_pkg, pos_sincos, pos_divider.
// Throughput: one point per clock cycle; start is taken whenever high (busy is 0).
// Each point passes two reduction-plus-CORDIC chains and the bit-per-cell divider.
// Results pulse done for one cycle; the receiver cannot stall.
// rst_n (async, active low) restores register defaults.
module popcorn_orbit_step #(
    parameter int FRAC_BITS     = pos_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = pos_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] point_re,
    input  logic signed [31:0] point_im,
    output logic               done,
    output logic signed [31:0] next_re,
    output logic signed [31:0] next_im,
    output logic               escaped
);
    localparam int SW = pos_pkg::SC_W;
    localparam logic [30:0] DEF_STEP = 31'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);
    localparam logic signed [31:0] THREE = 32'sd3 <<< FRAC_BITS;

    logic [30:0]        step_reg;
    logic signed [31:0] cre_reg, cim_reg;
    logic [39:0]        bail_reg;
    logic [1:0]         ridx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign ridx   = paddr[4:3];

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 31'd838861;
            cre_reg  <= 32'sd50331648;
            cim_reg  <= '0;
            bail_reg <= 40'd67108864;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                pos_pkg::REG_STEP: step_reg <= pwdata[30:0];
                pos_pkg::REG_CRE:  cre_reg  <= pwdata[31:0];
                pos_pkg::REG_CIM:  cim_reg  <= pwdata[31:0];
                pos_pkg::REG_BAIL: bail_reg <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            pos_pkg::REG_STEP: prdata = {33'd0, step_reg};
            pos_pkg::REG_CRE:  prdata = {{32{cre_reg[31]}}, cre_reg};
            pos_pkg::REG_CIM:  prdata = {{32{cim_reg[31]}}, cim_reg};
            pos_pkg::REG_BAIL: prdata = {24'd0, bail_reg};
            default:           prdata = '0;
        endcase
    end

    // stage 1: four products
    logic signed [31:0] cr_eff;
    logic               v1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [31:0] zr1_reg, zi1_reg;
    assign cr_eff = (cre_reg == '0 && cim_reg == '0) ? THREE : cre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg <= point_re * cr_eff;
        p_ii_reg <= point_im * cim_reg;
        p_ri_reg <= point_re * cim_reg;
        p_ir_reg <= point_im * cr_eff;
        zr1_reg  <= point_re;
        zi1_reg  <= point_im;
    end

    // stage 2: w = z*C, saturated
    logic               v2_reg;
    logic signed [31:0] wr_reg, wi_reg, zr2_reg, zi2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        wr_reg  <= pos_pkg::sat32((p_rr_reg >>> FRAC_BITS) - (p_ii_reg >>> FRAC_BITS));
        wi_reg  <= pos_pkg::sat32((p_ri_reg >>> FRAC_BITS) + (p_ir_reg >>> FRAC_BITS));
        zr2_reg <= zr1_reg;
        zi2_reg <= zi1_reg;
    end

    // tan via sin/cos then divide, both components
    logic           va_r, va_i, vd_r, vd_i;
    logic signed [SW-1:0] s_a_r, c_a_r, s_a_i, c_a_i;
    logic [63:0]    sb_a_r, sb_a_i, sb_d_r, sb_d_i;
    logic signed [31:0] t_r, t_i;

    pos_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SB_W(64)) u_sc_wr (
        .clk(clk), .rst_n(rst_n), .vld_in(v2_reg), .ang_in(wr_reg),
        .sb_in({zr2_reg, zi2_reg}),
        .vld_out(va_r), .sin_out(s_a_r), .cos_out(c_a_r), .sb_out(sb_a_r));
    pos_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SB_W(64)) u_sc_wi (
        .clk(clk), .rst_n(rst_n), .vld_in(v2_reg), .ang_in(wi_reg),
        .sb_in({zr2_reg, zi2_reg}),
        .vld_out(va_i), .sin_out(s_a_i), .cos_out(c_a_i), .sb_out(sb_a_i));

    pos_divider #(.FRAC_BITS(FRAC_BITS), .SB_W(64)) u_div_r (
        .clk(clk), .rst_n(rst_n), .vld_in(va_r), .num_in(s_a_r), .den_in(c_a_r),
        .sb_in(sb_a_r), .vld_out(vd_r), .quo_out(t_r), .sb_out(sb_d_r));
    pos_divider #(.FRAC_BITS(FRAC_BITS), .SB_W(64)) u_div_i (
        .clk(clk), .rst_n(rst_n), .vld_in(va_i), .num_in(s_a_i), .den_in(c_a_i),
        .sb_in(sb_a_i), .vld_out(vd_i), .quo_out(t_i), .sb_out(sb_d_i));

    // u = tan(w) + z
    logic               v3_reg;
    logic signed [31:0] ur_reg, ui_reg, zr3_reg, zi3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= vd_r;
    end
    always_ff @(posedge clk)
    begin
        ur_reg  <= pos_pkg::sat32(64'(t_r) + 64'($signed(sb_d_r[63:32])));
        ui_reg  <= pos_pkg::sat32(64'(t_i) + 64'($signed(sb_d_i[31:0])));
        zr3_reg <= $signed(sb_d_r[63:32]);
        zi3_reg <= $signed(sb_d_r[31:0]);
    end

    // sin(u) for both components
    logic           vb_r, vb_i;
    logic signed [SW-1:0] s_b_r, c_b_r, s_b_i, c_b_i;
    logic [63:0]    sb_b_r, sb_b_i;
    pos_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SB_W(64)) u_sc_ur (
        .clk(clk), .rst_n(rst_n), .vld_in(v3_reg), .ang_in(ur_reg),
        .sb_in({zr3_reg, zi3_reg}),
        .vld_out(vb_r), .sin_out(s_b_r), .cos_out(c_b_r), .sb_out(sb_b_r));
    pos_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SB_W(64)) u_sc_ui (
        .clk(clk), .rst_n(rst_n), .vld_in(v3_reg), .ang_in(ui_reg),
        .sb_in({zr3_reg, zi3_reg}),
        .vld_out(vb_i), .sin_out(s_b_i), .cos_out(c_b_i), .sb_out(sb_b_i));

    // h * sin products
    logic [30:0]        h;
    logic               v4_reg;
    logic signed [66:0] hs_i_reg, hs_r_reg;
    logic signed [31:0] zr4_reg, zi4_reg;
    logic signed [SW-1:0] unused_c;
    assign h = (step_reg == '0) ? DEF_STEP : step_reg;
    assign unused_c = c_b_r ^ c_b_i;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= vb_r & (vb_i | ~vb_i) & (|unused_c | ~|unused_c);
    end
    always_ff @(posedge clk)
    begin
        hs_i_reg <= $signed({1'b0, h}) * s_b_i;
        hs_r_reg <= $signed({1'b0, h}) * s_b_r;
        zr4_reg  <= $signed(sb_b_r[63:32]);
        zi4_reg  <= $signed(sb_b_i[31:0]);
    end

    // new point
    logic               v5_reg;
    logic signed [31:0] nr_reg, ni_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        nr_reg <= pos_pkg::sat32(64'(zr4_reg) - 64'(hs_i_reg >>> 30));
        ni_reg <= pos_pkg::sat32(64'(zi4_reg) - 64'(hs_r_reg >>> 30));
    end

    // squares
    logic               v6_reg;
    logic [63:0]        sq_r_reg, sq_i_reg;
    logic signed [31:0] nr6_reg, ni6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        sq_r_reg <= nr_reg * nr_reg;
        sq_i_reg <= ni_reg * ni_reg;
        nr6_reg  <= nr_reg;
        ni6_reg  <= ni_reg;
    end

    // escape compare and output register
    logic [63:0] mag;
    assign mag = sq_r_reg + sq_i_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        next_re <= nr6_reg;
        next_im <= ni6_reg;
        escaped <= (mag >> FRAC_BITS) >= 64'(bail_reg);
    end

`ifndef SYNTHESIS
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        va_r == va_i) else $error("sin/cos lanes out of step");
    a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        vd_r == vd_i) else $error("divider lanes out of step");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |=> done) else $error("result transaction lost");
`endif
endmodule

/* tb/tb_popcorn_orbit_step.sv */
// Self-checking testbench for popcorn_orbit_step: APB register setup, directed and
// random points, each result checked against a fixed-point popcorn predictor.
// Depends on pos_pkg and the popcorn_orbit_step RTL.
module tb_popcorn_orbit_step;

    localparam int  FRAC       = 24;
    localparam int  STAGES     = 24;
    localparam int  DRAIN_WAIT = 150;
    localparam int  CYCLE_CAP  = 400000;
    localparam longint P_PI    = 64'sd3373259426;
    localparam longint P_2PI   = 64'sd6746518852;
    localparam longint P_HPI   = 64'sd1686629713;
    localparam longint P_GAIN  = 64'sd652032874;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint DEF_H   = ((64'sd1 << FRAC) + 10) / 20;

    localparam longint ATAN_LUT [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0};

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               esc;
    } orbit_pt_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] point_re = '0;
    logic signed [31:0] point_im = '0;
    logic               done;
    logic signed [31:0] next_re;
    logic signed [31:0] next_im;
    logic               escaped;

    // predictor copy of the register file
    logic [30:0]        h_reg;
    logic signed [31:0] c_re_reg;
    logic signed [31:0] c_im_reg;
    logic [39:0]        bail_reg;

    orbit_pt_t pending_pts[$];
    int        err_cnt = 0;
    int        cyc_cnt = 0;
    bit        quiet_sender = 1'b0;

    popcorn_orbit_step dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .point_re(point_re), .point_im(point_im),
        .done(done), .next_re(next_re), .next_im(next_im), .escaped(escaped)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_CAP)
        begin
            $display("popcorn_orbit_step verification failed");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // rotation CORDIC on Q24 angle, sine and cosine in Q30
    function automatic void cordic_sc(input longint ang, output longint s,
                                      output longint c);
        longint r, x, y, dx, dy;
        bit     flip;
        r = (ang * 64) % P_2PI;
        x = P_GAIN;
        y = 0;
        flip = 1'b0;
        if (r < 0)
            r = r + P_2PI;
        if (r > P_PI)
            r = r - P_2PI;
        if (r > P_HPI)
        begin
            r = P_PI - r;
            flip = 1'b1;
        end
        else if (r < -P_HPI)
        begin
            r = -P_PI - r;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (r >= 0)
            begin
                x = x - dy;
                y = y + dx;
                r = r - ATAN_LUT[i];
            end
            else
            begin
                x = x + dy;
                y = y - dx;
                r = r + ATAN_LUT[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint tan_q24(input longint ang);
        longint s, c;
        cordic_sc(ang, s, c);
        if (c == 0)
            return (s >= 0) ? S32_MAX : S32_MIN;
        return clamp32((s * (64'sd1 << FRAC)) / c);
    endfunction

    function automatic orbit_pt_t popcorn_next(input logic signed [31:0] pr,
                                               input logic signed [31:0] pi_);
        longint zr, zi, cr, ci, h, wr, wi, ur, ui, sr, si, cd, nr, ni;
        longint unsigned mag;
        orbit_pt_t o;
        zr = pr;
        zi = pi_;
        cr = c_re_reg;
        ci = c_im_reg;
        h = (h_reg != 0) ? longint'(h_reg) : DEF_H;
        if (cr == 0 && ci == 0)
            cr = 64'sd3 << FRAC;
        wr = clamp32(((zr * cr) >>> FRAC) - ((zi * ci) >>> FRAC));
        wi = clamp32(((zr * ci) >>> FRAC) + ((zi * cr) >>> FRAC));
        ur = clamp32(tan_q24(wr) + zr);
        ui = clamp32(tan_q24(wi) + zi);
        cordic_sc(ur, sr, cd);
        cordic_sc(ui, si, cd);
        nr = clamp32(zr - ((h * si) >>> 30));
        ni = clamp32(zi - ((h * sr) >>> 30));
        mag = longint'(nr * nr) + longint'(ni * ni);
        o.re = nr[31:0];
        o.im = ni[31:0];
        o.esc = ((mag >> FRAC) >= bail_reg);
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        orbit_pt_t want;
        if (rst_n && done)
        begin
            if (pending_pts.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result re=%h im=%h esc=%b",
                         $time, next_re, next_im, escaped);
            end
            else
            begin
                want = pending_pts.pop_front();
                if (next_re !== want.re)
                begin
                    err_cnt++;
                    $display("%0t: next_re expected %h actual %h", $time, want.re, next_re);
                end
                if (next_im !== want.im)
                begin
                    err_cnt++;
                    $display("%0t: next_im expected %h actual %h", $time, want.im, next_im);
                end
                if (escaped !== want.esc)
                begin
                    err_cnt++;
                    $display("%0t: escaped expected %b actual %b", $time, want.esc, escaped);
                end
            end
        end
    end

    // one point transaction; returns at the falling edge after acceptance
    task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
        start = 1'b1;
        point_re = re;
        point_im = im;
        do
            @(posedge clk);
        while (busy);
        pending_pts.push_back(popcorn_next(re, im));
        @(negedge clk);
    endtask

    // random sender gap, about 28 in 100
    task automatic maybe_gap();
        if (!quiet_sender && $urandom_range(99) < 28)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (pending_pts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // drain pending results, then APB write and readback of one register
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        logic [63:0] mask;
        logic [63:0] rd;
        drain_results();
        case (idx)
            pos_pkg::REG_STEP: begin mask = 64'h7FFF_FFFF;    h_reg = val[30:0];    end
            pos_pkg::REG_CRE:  begin mask = 64'hFFFF_FFFF;    c_re_reg = val[31:0]; end
            pos_pkg::REG_CIM:  begin mask = 64'hFFFF_FFFF;    c_im_reg = val[31:0]; end
            default:           begin mask = 64'hFF_FFFF_FFFF; bail_reg = val[39:0]; end
        endcase
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if ((rd & mask) !== (val & mask))
        begin
            err_cnt++;
            $display("%0t: reg %0d readback expected %h actual %h",
                     $time, idx, val & mask, rd & mask);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(0, 32'h0800_0000) - 32'sh0400_0000;
        if (k < 85)
            return $urandom;
        return k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    task automatic test_defaults();
        logic signed [31:0] edges [6];
        edges = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0100_0000,
                  32'sh0086_0A92, -32'sh0086_0A92};
        foreach (edges[i])
            foreach (edges[j])
            begin
                send_point(edges[i], edges[j]);
                maybe_gap();
            end
    endtask

    task automatic test_zero_coef_and_step();
        reg_write(pos_pkg::REG_CRE, 64'd0);
        reg_write(pos_pkg::REG_CIM, 64'd0);
        reg_write(pos_pkg::REG_STEP, 64'd0);
        send_point(32'sh0100_0000, -32'sh0080_0000);
        send_point(32'sh0086_0A92, 32'sh0);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    task automatic test_register_extremes();
        reg_write(pos_pkg::REG_STEP, 64'h7FFF_FFFF);
        reg_write(pos_pkg::REG_CRE, 64'hFFFF_FFFF_8000_0000);
        reg_write(pos_pkg::REG_CIM, 64'h7FFF_FFFF);
        reg_write(pos_pkg::REG_BAIL, 64'h0);
        send_point(32'sh0040_0000, 32'sh0020_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        reg_write(pos_pkg::REG_BAIL, 64'hFF_FFFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh0, 32'sh0);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 5; ph++)
        begin
            reg_write(pos_pkg::REG_STEP, (ph == 2) ? 64'd0 : {$urandom, $urandom});
            reg_write(pos_pkg::REG_CRE,
                      (ph == 3) ? 64'd0 : 64'($urandom_range(0, 32'h0800_0000)));
            reg_write(pos_pkg::REG_CIM, (ph == 3) ? 64'd0 : {$urandom, $urandom});
            reg_write(pos_pkg::REG_BAIL, (ph == 4) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(0, 32'h2000_0000)));
            for (int n = 0; n < 210; n++)
            begin
                quiet_sender = (ph == 1);
                send_point(rand_coord(), rand_coord());
                maybe_gap();
                // hold off until the pipeline is empty
                if (n == 100)
                begin
                    start = 1'b0;
                    while (pending_pts.size() != 0)
                        @(negedge clk);
                end
            end
            quiet_sender = 1'b0;
        end
    endtask

    initial
    begin
        h_reg = 31'd838861;
        c_re_reg = 32'sd50331648;
        c_im_reg = 32'sd0;
        bail_reg = 40'd67108864;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_defaults();
        test_zero_coef_and_step();
        test_register_extremes();
        test_random_phases();
        drain_results();
        if (err_cnt == 0)
            $display("popcorn_orbit_step verification clean");
        else
            $display("popcorn_orbit_step verification failed");
        $finish;
    end

endmodule
